@@ rtl/sct_pkg.sv @@
package sct_pkg;

  localparam int CoordW = 32;
  localparam int DiffW  = CoordW + 1;
  localparam int ProdW  = 2 * DiffW;
  localparam int WideW  = ProdW + 2;
  localparam int NumW   = WideW + DiffW;
  localparam int TolW   = 16;
  localparam int HiW    = WideW - DiffW;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [DiffW-1:0]  diff_t;
  typedef logic [DiffW-1:0]         udiff_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [WideW-1:0]  wide_t;
  typedef logic [WideW-1:0]         uwide_t;
  typedef logic [NumW-1:0]          num_t;
  typedef logic [TolW-1:0]          tol_t;

  typedef struct packed {
    logic   strict;
    logic   last;
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
    coord_t cx;
    coord_t cy;
    coord_t dx;
    coord_t dy;
  } side_t;

  typedef struct packed {
    logic ident;
    logic ok;
    logic neg_x;
    logic neg_y;
  } flag_t;

  function automatic diff_t sx(input coord_t c);
    return {c[CoordW-1], c};
  endfunction

  function automatic logic near1(input coord_t a, input coord_t b, input tol_t tol);
    diff_t  d;
    udiff_t m;
    d = sx(a) - sx(b);
    m = d[DiffW-1] ? udiff_t'(-d) : udiff_t'(d);
    return m < udiff_t'(tol);
  endfunction

  function automatic logic near2(input coord_t ax, input coord_t ay,
                                 input coord_t bx, input coord_t by, input tol_t tol);
    return near1(ax, bx, tol) && near1(ay, by, tol);
  endfunction

endpackage

@@ rtl/sct_front.sv @@
module sct_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  sct_pkg::side_t side_i,
  input  sct_pkg::tol_t  tol_i,
  output logic           valid_o,
  output sct_pkg::side_t side_o,
  output sct_pkg::flag_t flag_o,
  output sct_pkg::uwide_t tabs_o,
  output sct_pkg::uwide_t dabs_o,
  output sct_pkg::udiff_t s1x_abs_o,
  output sct_pkg::udiff_t s1y_abs_o
);

  logic v1_q, v2_q, v3_q, v4_q;
  sct_pkg::side_t side1_q, side2_q, side3_q, side4_q;
  logic ident1_q, ident2_q, ident3_q;
  sct_pkg::diff_t s1x_q, s1y_q, s2x_q, s2y_q, ox_q, oy_q;
  sct_pkg::diff_t s1x2_q, s1y2_q, s1x3_q, s1y3_q;
  sct_pkg::prod_t p0_q, p1_q, p2_q, p3_q, p4_q, p5_q;
  sct_pkg::wide_t den_q, snum_q, tnum_q;
  sct_pkg::flag_t flag_d, flag_q;
  sct_pkg::uwide_t tabs_d, dabs_d, tabs_q, dabs_q;
  sct_pkg::udiff_t s1xa_q, s1ya_q;
  sct_pkg::wide_t sn, tn, dab;
  logic dneg, ident_d;

  // identical edge in either direction
  assign ident_d =
    (sct_pkg::near2(side_i.ax, side_i.ay, side_i.cx, side_i.cy, tol_i) &&
     sct_pkg::near2(side_i.bx, side_i.by, side_i.dx, side_i.dy, tol_i)) ||
    (sct_pkg::near2(side_i.bx, side_i.by, side_i.cx, side_i.cy, tol_i) &&
     sct_pkg::near2(side_i.ax, side_i.ay, side_i.dx, side_i.dy, tol_i));

  always_comb begin
    dneg = den_q[sct_pkg::WideW-1];
    dab  = dneg ? -den_q : den_q;
    sn   = dneg ? -snum_q : snum_q;
    tn   = dneg ? -tnum_q : tnum_q;
    flag_d.ident = ident3_q;
    flag_d.ok = (den_q != '0) &&
                !(dab < sct_pkg::wide_t'({tol_i, 16'h0000})) &&
                !sn[sct_pkg::WideW-1] && (sn <= dab) &&
                !tn[sct_pkg::WideW-1] && (tn <= dab);
    flag_d.neg_x = tnum_q[sct_pkg::WideW-1] ^ s1x3_q[sct_pkg::DiffW-1] ^ dneg;
    flag_d.neg_y = tnum_q[sct_pkg::WideW-1] ^ s1y3_q[sct_pkg::DiffW-1] ^ dneg;
    tabs_d = tnum_q[sct_pkg::WideW-1] ? sct_pkg::uwide_t'(-tnum_q)
                                      : sct_pkg::uwide_t'(tnum_q);
    dabs_d = sct_pkg::uwide_t'(dab);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // differences
      side1_q  <= side_i;
      ident1_q <= ident_d;
      s1x_q <= sct_pkg::sx(side_i.bx) - sct_pkg::sx(side_i.ax);
      s1y_q <= sct_pkg::sx(side_i.by) - sct_pkg::sx(side_i.ay);
      s2x_q <= sct_pkg::sx(side_i.dx) - sct_pkg::sx(side_i.cx);
      s2y_q <= sct_pkg::sx(side_i.dy) - sct_pkg::sx(side_i.cy);
      ox_q  <= sct_pkg::sx(side_i.ax) - sct_pkg::sx(side_i.cx);
      oy_q  <= sct_pkg::sx(side_i.ay) - sct_pkg::sx(side_i.cy);
      // products
      side2_q  <= side1_q;
      ident2_q <= ident1_q;
      s1x2_q <= s1x_q;
      s1y2_q <= s1y_q;
      p0_q <= s1x_q * s2y_q;
      p1_q <= s2x_q * s1y_q;
      p2_q <= s1x_q * oy_q;
      p3_q <= s1y_q * ox_q;
      p4_q <= s2x_q * oy_q;
      p5_q <= s2y_q * ox_q;
      // cross products
      side3_q  <= side2_q;
      ident3_q <= ident2_q;
      s1x3_q <= s1x2_q;
      s1y3_q <= s1y2_q;
      den_q  <= sct_pkg::wide_t'(p0_q) - sct_pkg::wide_t'(p1_q);
      snum_q <= sct_pkg::wide_t'(p2_q) - sct_pkg::wide_t'(p3_q);
      tnum_q <= sct_pkg::wide_t'(p4_q) - sct_pkg::wide_t'(p5_q);
      // range tests and magnitudes
      side4_q <= side3_q;
      flag_q  <= flag_d;
      tabs_q  <= tabs_d;
      dabs_q  <= dabs_d;
      s1xa_q  <= s1x3_q[sct_pkg::DiffW-1] ? sct_pkg::udiff_t'(-s1x3_q)
                                          : sct_pkg::udiff_t'(s1x3_q);
      s1ya_q  <= s1y3_q[sct_pkg::DiffW-1] ? sct_pkg::udiff_t'(-s1y3_q)
                                          : sct_pkg::udiff_t'(s1y3_q);
    end
  end

  assign valid_o   = v4_q;
  assign side_o    = side4_q;
  assign flag_o    = flag_q;
  assign tabs_o    = tabs_q;
  assign dabs_o    = dabs_q;
  assign s1x_abs_o = s1xa_q;
  assign s1y_abs_o = s1ya_q;

endmodule

@@ rtl/sct_mul.sv @@
module sct_mul (
  input  logic            clk_i,
  input  logic            en_i,
  input  sct_pkg::uwide_t a_i,
  input  sct_pkg::udiff_t b_i,
  output sct_pkg::num_t   n_o
);

  logic [2*sct_pkg::DiffW-1:0]         pl_q;
  logic [sct_pkg::HiW+sct_pkg::DiffW-1:0] ph_q;
  sct_pkg::num_t n_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pl_q <= a_i[sct_pkg::DiffW-1:0] * b_i;
      ph_q <= a_i[sct_pkg::WideW-1:sct_pkg::DiffW] * b_i;
      n_q  <= (sct_pkg::num_t'(ph_q) << sct_pkg::DiffW) + sct_pkg::num_t'(pl_q);
    end
  end

  assign n_o = n_q;

endmodule

@@ rtl/sct_div.sv @@
module sct_div (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  sct_pkg::side_t  side_i,
  input  sct_pkg::flag_t  flag_i,
  input  sct_pkg::num_t   nx_i,
  input  sct_pkg::num_t   ny_i,
  input  sct_pkg::uwide_t d_i,
  output logic            valid_o,
  output sct_pkg::side_t  side_o,
  output sct_pkg::flag_t  flag_o,
  output sct_pkg::udiff_t qx_o,
  output sct_pkg::udiff_t qy_o
);

  localparam int N = sct_pkg::DiffW;

  logic            v_q    [N];
  sct_pkg::side_t  side_q [N];
  sct_pkg::flag_t  flag_q [N];
  sct_pkg::num_t   rx_q   [N];
  sct_pkg::num_t   ry_q   [N];
  sct_pkg::uwide_t d_q    [N];
  sct_pkg::udiff_t qx_q   [N];
  sct_pkg::udiff_t qy_q   [N];

  // one quotient bit per stage, most significant first
  for (genvar k = 0; k < N; k++) begin : g_st
    localparam int Sh = N - 1 - k;
    logic            v_in;
    sct_pkg::side_t  side_in;
    sct_pkg::flag_t  flag_in;
    sct_pkg::num_t   rx_in, ry_in, trial;
    sct_pkg::uwide_t d_in;
    sct_pkg::udiff_t qx_in, qy_in;
    logic            gx, gy;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign side_in = side_i;
      assign flag_in = flag_i;
      assign rx_in   = nx_i;
      assign ry_in   = ny_i;
      assign d_in    = d_i;
      assign qx_in   = '0;
      assign qy_in   = '0;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign side_in = side_q[k-1];
      assign flag_in = flag_q[k-1];
      assign rx_in   = rx_q[k-1];
      assign ry_in   = ry_q[k-1];
      assign d_in    = d_q[k-1];
      assign qx_in   = qx_q[k-1];
      assign qy_in   = qy_q[k-1];
    end

    assign trial = sct_pkg::num_t'(d_in) << Sh;
    assign gx    = rx_in >= trial;
    assign gy    = ry_in >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= side_in;
        flag_q[k] <= flag_in;
        d_q[k]    <= d_in;
        rx_q[k]   <= gx ? rx_in - trial : rx_in;
        ry_q[k]   <= gy ? ry_in - trial : ry_in;
        qx_q[k]   <= qx_in | (sct_pkg::udiff_t'(gx) << Sh);
        qy_q[k]   <= qy_in | (sct_pkg::udiff_t'(gy) << Sh);
      end
    end
  end

  assign valid_o = v_q[N-1];
  assign side_o  = side_q[N-1];
  assign flag_o  = flag_q[N-1];
  assign qx_o    = qx_q[N-1];
  assign qy_o    = qy_q[N-1];

endmodule

@@ rtl/segment_crossing_test.sv @@
// path from input beat to output beat: front, multiply, divide and finish stages,
//   one quotient bit per divider stage
// throughput: one beat per cycle; all stages stall together on output back-pressure
// reset: asynchronous active low, clears all valid bits, tolerance returns to 1
module segment_crossing_test (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // query_a_x, query_a_y, query_b_x, query_b_y, edge_a_x, edge_a_y, edge_b_x, edge_b_y
  input  logic [8*sct_pkg::CoordW-1:0] s_axis_tdata,
  // req_type
  input  logic [0:0]  s_axis_tuser,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // point_x, point_y
  output logic [2*sct_pkg::CoordW-1:0] m_axis_tdata,
  // crosses, point_valid
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [sct_pkg::TolW-1:0] cfg_wdata_i
);

  localparam int CW = sct_pkg::CoordW;

  sct_pkg::tol_t tol_q;
  logic en;
  sct_pkg::side_t side_in;

  logic            v4;
  sct_pkg::side_t  side4;
  sct_pkg::flag_t  flag4;
  sct_pkg::uwide_t tabs4, dabs4;
  sct_pkg::udiff_t s1xa4, s1ya4;

  logic            v5_q, v6_q;
  sct_pkg::side_t  side5_q, side6_q;
  sct_pkg::flag_t  flag5_q, flag6_q;
  sct_pkg::uwide_t dabs5_q, dabs6_q;
  sct_pkg::num_t   nx6, ny6;

  logic            vd;
  sct_pkg::side_t  sided;
  sct_pkg::flag_t  flagd;
  sct_pkg::udiff_t qxd, qyd;

  logic            v7_q, out_v_q;
  sct_pkg::side_t  side7_q;
  sct_pkg::flag_t  flag7_q;
  sct_pkg::coord_t px7_q, py7_q, px_d, py_d;
  logic            hit_end, cross_d, pv_d;
  sct_pkg::diff_t  sumx, sumy;
  logic [2*CW-1:0] out_data_q;
  logic [1:0]      out_user_q;
  logic            out_last_q;

  assign en = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  assign side_in.strict = s_axis_tuser[0];
  assign side_in.last   = s_axis_tlast;
  assign side_in.ax     = s_axis_tdata[1*CW-1:0*CW];
  assign side_in.ay     = s_axis_tdata[2*CW-1:1*CW];
  assign side_in.bx     = s_axis_tdata[3*CW-1:2*CW];
  assign side_in.by     = s_axis_tdata[4*CW-1:3*CW];
  assign side_in.cx     = s_axis_tdata[5*CW-1:4*CW];
  assign side_in.cy     = s_axis_tdata[6*CW-1:5*CW];
  assign side_in.dx     = s_axis_tdata[7*CW-1:6*CW];
  assign side_in.dy     = s_axis_tdata[8*CW-1:7*CW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= sct_pkg::TolW'(1);
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  sct_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (s_axis_tvalid),
    .side_i    (side_in),
    .tol_i     (tol_q),
    .valid_o   (v4),
    .side_o    (side4),
    .flag_o    (flag4),
    .tabs_o    (tabs4),
    .dabs_o    (dabs4),
    .s1x_abs_o (s1xa4),
    .s1y_abs_o (s1ya4)
  );

  sct_mul u_mul_x (.clk_i(clk_i), .en_i(en), .a_i(tabs4), .b_i(s1xa4), .n_o(nx6));
  sct_mul u_mul_y (.clk_i(clk_i), .en_i(en), .a_i(tabs4), .b_i(s1ya4), .n_o(ny6));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q    <= 1'b0;
      v6_q    <= 1'b0;
      v7_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      v5_q    <= v4;
      v6_q    <= v5_q;
      v7_q    <= vd;
      out_v_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side5_q <= side4;
      flag5_q <= flag4;
      dabs5_q <= dabs4;
      side6_q <= side5_q;
      flag6_q <= flag5_q;
      dabs6_q <= dabs5_q;
    end
  end

  sct_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v6_q),
    .side_i  (side6_q),
    .flag_i  (flag6_q),
    .nx_i    (nx6),
    .ny_i    (ny6),
    .d_i     (dabs6_q),
    .valid_o (vd),
    .side_o  (sided),
    .flag_o  (flagd),
    .qx_o    (qxd),
    .qy_o    (qyd)
  );

  // contact point from start of query segment
  always_comb begin
    sumx = flagd.neg_x ? sct_pkg::sx(sided.ax) - sct_pkg::diff_t'(qxd)
                       : sct_pkg::sx(sided.ax) + sct_pkg::diff_t'(qxd);
    sumy = flagd.neg_y ? sct_pkg::sx(sided.ay) - sct_pkg::diff_t'(qyd)
                       : sct_pkg::sx(sided.ay) + sct_pkg::diff_t'(qyd);
    px_d = sumx[CW-1:0];
    py_d = sumy[CW-1:0];
  end

  // strict mode rejects contacts at any endpoint
  always_comb begin
    hit_end = sct_pkg::near2(px7_q, py7_q, side7_q.ax, side7_q.ay, tol_q) ||
              sct_pkg::near2(px7_q, py7_q, side7_q.bx, side7_q.by, tol_q) ||
              sct_pkg::near2(px7_q, py7_q, side7_q.cx, side7_q.cy, tol_q) ||
              sct_pkg::near2(px7_q, py7_q, side7_q.dx, side7_q.dy, tol_q);
    pv_d    = !flag7_q.ident && flag7_q.ok;
    cross_d = flag7_q.ident ? !side7_q.strict : (pv_d && !(side7_q.strict && hit_end));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side7_q    <= sided;
      flag7_q    <= flagd;
      px7_q      <= px_d;
      py7_q      <= py_d;
      out_data_q <= pv_d ? {py7_q, px7_q} : '0;
      out_user_q <= {pv_d, cross_d};
      out_last_q <= side7_q.last;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

endmodule

@@ rtl/sct_check.sv @@
module sct_check (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [2*sct_pkg::CoordW-1:0] m_axis_tdata,
  input logic [1:0] m_axis_tuser,
  input logic m_axis_tlast
);

  // input side opens whenever the output register can move
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output register");

  // no contact point means a zero point
  a_zero_pt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[1]) |-> (m_axis_tdata == '0))
    else $error("point reported without point_valid");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("output beat dropped under stall");

  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      ($stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast)))
    else $error("output beat changed under stall");

endmodule

bind segment_crossing_test sct_check u_sct_check (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
